// File: design/ps_pkg.sv
// shared types and constants for the priority scheduler
// no dependencies
package ps_pkg;

   localparam int MaxProcs = 64;
   localparam int IdxW     = $clog2(MaxProcs);
   localparam int CntW     = $clog2(MaxProcs + 1);
   localparam int TimeW    = 23;
   localparam int SumW     = 29;

   typedef struct packed {
      logic [15:0] arrive_at;
      logic [15:0] run_len;
      logic [7:0]  priority_req;
      logic        last_process;
   } req_type;

   typedef struct packed {
      logic [5:0]       process_index;
      logic [TimeW-1:0] start_at;
      logic [TimeW-1:0] finish_at;
      logic [TimeW-1:0] turnaround;
      logic [TimeW-1:0] wait_len;
      logic [TimeW-1:0] respond_len;
      logic [SumW-1:0]  sum_turnaround;
      logic [SumW-1:0]  sum_waiting;
      logic [SumW-1:0]  sum_response;
      logic [TimeW-1:0] sum_idle;
      logic             last_result;
   } rsp_type;

   // one stored process as it travels around the ring
   typedef struct packed {
      logic [15:0]     arrival;
      logic [15:0]     burst;
      logic [7:0]      prio;
      logic [IdxW-1:0] idx;
      logic            pend;
   } entry_type;

   // control broadcast to every cell
   typedef struct packed {
      logic            shift;
      logic            done_en;
      logic [IdxW-1:0] done_idx;
   } cell_ctl_type;

endpackage

// File: design/priority_schedule.sv
// non-preemptive priority scheduler top level: process ring and sequencer
// depends on ps_pkg and ps_cell
// after the last transfer the ring makes one full rotation of the ring per pick,
// then the pick is computed and sent, for each result in turn;
// loads are taken back to back while idle; no new load until the last result of the batch
// sits in the output register
// reset: synchronous, clears ring pending bits, counters, totals and fsm
module priority_schedule (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  ps_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output ps_pkg::rsp_type rsp_data
);
   import ps_pkg::*;

   typedef enum logic [1:0] {IDLE, SCAN, CALC, SEND} state_type;

   state_type        state_ff;
   logic [CntW-1:0]  count_ff;      // loaded processes
   logic [CntW-1:0]  remain_ff;     // results still to send
   logic [IdxW-1:0]  step_ff;       // ring rotation counter
   logic [TimeW-1:0] clock_now_ff;  // also the previous finish time
   logic [SumW-1:0]  tat_sum_ff, wt_sum_ff, rt_sum_ff;
   logic [TimeW-1:0] idle_sum_ff;
   entry_type        best_ff, pend_ff;
   logic             found_ff, pfound_ff;
   entry_type        sel_ff;
   logic [TimeW-1:0] st_ff, ct_ff, rt_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;
   logic             done_en_ff;
   logic [IdxW-1:0]  done_idx_ff;

   cell_ctl_type ctl;
   entry_type    ring [MaxProcs];
   entry_type    load_data;
   entry_type    head;
   logic         req_fire, has_room;
   logic         ready_hit, better, pend_better;
   logic [TimeW-1:0] st_c, tat_sum_w;

   assign req_fire = req_valid && req_ready;
   assign req_ready = (state_ff == IDLE);
   assign has_room = (count_ff < CntW'(MaxProcs));

   assign load_data.arrival = req_data.arrive_at;
   assign load_data.burst   = req_data.run_len;
   assign load_data.prio    = req_data.priority_req;
   assign load_data.idx     = count_ff[IdxW-1:0];
   assign load_data.pend    = 1'b1;

   // ring holds still in the first send cycle, so the pick's pending bit
   // is cleared there before the next rotation starts
   assign ctl.shift    = (state_ff == SCAN);
   assign ctl.done_en  = done_en_ff;
   assign ctl.done_idx = done_idx_ff;

   // ring of cells, rotating toward index 0
   for (genvar i = 0; i < MaxProcs; i++) begin : g_cell
      ps_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .load_en   (req_fire && has_room && count_ff[IdxW-1:0] == IdxW'(i)),
         .load_data (load_data),
         .nbr       (ring[(i + 1) % MaxProcs]),
         .entry     (ring[i])
      );
   end

   assign head = ring[0];

   // pick comparators on the entry at the head of the ring
   assign ready_hit = head.pend && ({7'd0, head.arrival} <= clock_now_ff);
   assign better = !found_ff || head.prio > best_ff.prio ||
                   (head.prio == best_ff.prio && head.arrival < best_ff.arrival);
   // fallback when nothing has arrived: earliest arrival, then highest priority
   assign pend_better = !pfound_ff || head.arrival < pend_ff.arrival ||
                        (head.arrival == pend_ff.arrival && head.prio > pend_ff.prio);

   assign st_c = found_ff ? clock_now_ff : {7'd0, pend_ff.arrival};
   assign tat_sum_w = rt_ff + {7'd0, sel_ff.burst};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         step_ff      <= '0;
         clock_now_ff <= '0;
         tat_sum_ff   <= '0;
         wt_sum_ff    <= '0;
         rt_sum_ff    <= '0;
         idle_sum_ff  <= '0;
         found_ff     <= 1'b0;
         pfound_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         done_en_ff   <= 1'b0;
      end else begin
         done_en_ff <= (state_ff == CALC);
         // outside send the output register only drains
         if (rsp_valid_ff && rsp_ready && state_ff != SEND) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            IDLE: begin
               if (req_fire) begin
                  if (has_room) begin
                     count_ff <= count_ff + 1'b1;
                  end
                  if (req_data.last_process) begin
                     remain_ff <= has_room ? count_ff + 1'b1 : count_ff;
                     step_ff   <= '0;
                     found_ff  <= 1'b0;
                     pfound_ff <= 1'b0;
                     state_ff  <= SCAN;
                  end
               end
            end
            SCAN: begin
               if (ready_hit && better) begin
                  best_ff  <= head;
                  found_ff <= 1'b1;
               end
               if (head.pend && pend_better) begin
                  pend_ff   <= head;
                  pfound_ff <= 1'b1;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == IdxW'(MaxProcs - 1)) begin
                  state_ff <= CALC;
               end
            end
            CALC: begin
               sel_ff      <= found_ff ? best_ff : pend_ff;
               st_ff       <= st_c;
               ct_ff       <= st_c + {7'd0, (found_ff ? best_ff.burst : pend_ff.burst)};
               rt_ff       <= st_c - {7'd0, (found_ff ? best_ff.arrival : pend_ff.arrival)};
               done_idx_ff <= found_ff ? best_ff.idx : pend_ff.idx;
               state_ff    <= SEND;
            end
            SEND: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff                <= 1'b1;
                  rsp_ff.process_index        <= sel_ff.idx;
                  rsp_ff.start_at             <= st_ff;
                  rsp_ff.finish_at            <= ct_ff;
                  rsp_ff.turnaround           <= tat_sum_w;
                  rsp_ff.wait_len             <= rt_ff;
                  rsp_ff.respond_len          <= rt_ff;
                  rsp_ff.sum_turnaround       <= tat_sum_ff + {6'd0, tat_sum_w};
                  rsp_ff.sum_waiting          <= wt_sum_ff + {6'd0, rt_ff};
                  rsp_ff.sum_response         <= rt_sum_ff + {6'd0, rt_ff};
                  rsp_ff.sum_idle             <= idle_sum_ff + (st_ff - clock_now_ff);
                  rsp_ff.last_result          <= (remain_ff == CntW'(1));
                  remain_ff   <= remain_ff - 1'b1;
                  step_ff     <= '0;
                  found_ff    <= 1'b0;
                  pfound_ff   <= 1'b0;
                  if (remain_ff == CntW'(1)) begin
                     // batch over: clear for the next one
                     count_ff     <= '0;
                     clock_now_ff <= '0;
                     tat_sum_ff   <= '0;
                     wt_sum_ff    <= '0;
                     rt_sum_ff    <= '0;
                     idle_sum_ff  <= '0;
                     state_ff     <= IDLE;
                  end else begin
                     clock_now_ff <= ct_ff;
                     tat_sum_ff   <= tat_sum_ff + {6'd0, tat_sum_w};
                     wt_sum_ff    <= wt_sum_ff + {6'd0, rt_ff};
                     rt_sum_ff    <= rt_sum_ff + {6'd0, rt_ff};
                     idle_sum_ff  <= idle_sum_ff + (st_ff - clock_now_ff);
                     state_ff     <= SCAN;
                  end
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/ps_cell.sv
// one slot of the rotating process ring
// depends on ps_pkg
module ps_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  ps_pkg::cell_ctl_type ctl,
   input  logic                 load_en,
   input  ps_pkg::entry_type    load_data,
   input  ps_pkg::entry_type    nbr,
   output ps_pkg::entry_type    entry
);
   import ps_pkg::*;

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (load_en) begin
         entry_in = load_data;
      end else if (ctl.shift) begin
         entry_in = nbr;
      end else if (ctl.done_en && entry_ff.idx == ctl.done_idx) begin
         entry_in.pend = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

// File: verif/testbench.sv
// self-checking testbench for the priority_schedule block
// depends on ps_pkg and the design sources; drives process batches, checks every schedule result
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ps_pkg::*;

   localparam int ProcCap    = 64;
   localparam int CycleLimit = 3000000;
   localparam int ItemTarget = 270;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   priority_schedule DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // predictor copy of the batch
   logic [15:0] arr_tab [ProcCap];
   logic [15:0] burst_tab [ProcCap];
   logic [7:0]  prio_tab [ProcCap];
   int          n_loaded;

   rsp_type schedule_q [$];
   int      n_errors;
   int      n_results;
   int      n_batches;
   int      n_items;
   longint  cycle_count = 0;

   // receiver control
   bit hold_off;      // long stall requested by a test
   int stall_mode;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // schedule the loaded batch exactly as the block should, push one result per process
   task automatic schedule_batch();
      bit          finished [ProcCap];
      logic [22:0] now, prev_end, st, ct, tat, wt, rt;
      logic [28:0] tat_sum, wt_sum, rt_sum;
      logic [22:0] idle_sum;
      int          pick;
      int          earliest;
      rsp_type     r;
      now = '0; prev_end = '0; tat_sum = '0; wt_sum = '0; rt_sum = '0; idle_sum = '0;
      foreach (finished[i]) finished[i] = 0;
      for (int k = 0; k < n_loaded; k++) begin
         pick = -1;
         for (int pass = 0; pass < 2 && pick < 0; pass++) begin
            if (pass == 1) begin
               // nothing ready: jump to the earliest pending arrival
               earliest = 32'h7fffffff;
               for (int i = 0; i < n_loaded; i++)
                  if (!finished[i] && arr_tab[i] < earliest) earliest = int'(arr_tab[i]);
               now = earliest[22:0];
            end
            for (int i = 0; i < n_loaded; i++) begin
               if (finished[i] || arr_tab[i] > now) continue;
               if (pick < 0 || prio_tab[i] > prio_tab[pick] ||
                   (prio_tab[i] == prio_tab[pick] && arr_tab[i] < arr_tab[pick]))
                  pick = i;
            end
         end
         st  = now;
         ct  = st + burst_tab[pick];
         tat = ct - arr_tab[pick];
         wt  = tat - burst_tab[pick];
         rt  = st - arr_tab[pick];
         tat_sum  = tat_sum + tat;
         wt_sum   = wt_sum + wt;
         rt_sum   = rt_sum + rt;
         idle_sum = idle_sum + (st - prev_end);
         finished[pick] = 1;
         now = ct;
         prev_end = ct;
         r.process_index   = pick[5:0];
         r.start_at        = st;
         r.finish_at       = ct;
         r.turnaround      = tat;
         r.wait_len        = wt;
         r.respond_len     = rt;
         r.sum_turnaround  = tat_sum;
         r.sum_waiting     = wt_sum;
         r.sum_response    = rt_sum;
         r.sum_idle        = idle_sum;
         r.last_result     = (k == n_loaded - 1);
         schedule_q.push_back(r);
      end
      n_loaded = 0;
      n_batches++;
   endtask

   // one process load transfer; valid stays high across back-to-back items
   task automatic load_process(input logic [15:0] arr, input logic [15:0] burst,
                               input logic [7:0] prio, input bit last);
      req_type item;
      item.arrive_at    = arr;
      item.run_len      = burst;
      item.priority_req = prio;
      item.last_process = last;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      // transfer happened at this edge, update the predictor copy
      if (n_loaded < ProcCap) begin
         arr_tab[n_loaded]   = arr;
         burst_tab[n_loaded] = burst;
         prio_tab[n_loaded]  = prio;
         n_loaded++;
      end
      if (last) schedule_batch();
      n_items++;
   endtask

   // sender gap: drop valid for a random number of cycles
   task automatic sender_gap(input int max_gap);
      int g;
      g = $urandom_range(0, max_gap);
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (schedule_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // random batch of n processes, random burst pattern of sender activity
   task automatic random_batch(input int n, input int arr_span, input int prio_span);
      int burst_left;
      burst_left = $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
         load_process(16'($urandom_range(0, arr_span)),
                      16'($urandom_range(0, 65535) >> $urandom_range(0, 12)),
                      8'($urandom_range(0, prio_span)), i == n - 1);
         if (--burst_left == 0) begin
            sender_gap(6);
            burst_left = $urandom_range(1, 8);
         end
      end
   endtask

   // directed: field extremes, ties, idle jumps, zero bursts
   task automatic test_directed();
      // single process, all zero
      load_process(16'h0000, 16'h0000, 8'h00, 1'b1);
      // single process, max fields
      load_process(16'hffff, 16'hffff, 8'hff, 1'b1);
      // priority ties broken by arrival, then by index
      load_process(16'd5, 16'd3, 8'd7, 1'b0);
      load_process(16'd2, 16'd4, 8'd7, 1'b0);
      load_process(16'd2, 16'd1, 8'd7, 1'b0);
      load_process(16'd0, 16'd0, 8'd1, 1'b1);
      // idle gaps forcing time jumps, zero bursts
      load_process(16'd100, 16'd0, 8'd3, 1'b0);
      load_process(16'd40000, 16'd10, 8'd200, 1'b0);
      load_process(16'd65535, 16'd65535, 8'd255, 1'b0);
      load_process(16'd50, 16'd60000, 8'd0, 1'b1);
      // alternating bit patterns
      load_process(16'haaaa, 16'h5555, 8'haa, 1'b0);
      load_process(16'h5555, 16'haaaa, 8'h55, 1'b1);
      wait_drained();
   endtask

   // full batch plus overflow items that must be dropped
   task automatic test_batch_full();
      for (int i = 0; i < ProcCap + 3; i++)
         load_process(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      8'($urandom_range(0, 255)), 1'b0);
      // dropped item whose last mark still starts scheduling
      load_process(16'hffff, 16'hffff, 8'hff, 1'b1);
      wait_drained();
   endtask

   // long receiver stall while the sender keeps offering
   task automatic test_backpressure();
      hold_off = 1'b1;
      random_batch(6, 200, 3);
      fork
         random_batch(5, 200, 3);
         begin
            repeat (400) @(posedge clock);
            hold_off = 1'b0;
         end
      join
      wait_drained();
   endtask

   // random batches, mostly small sizes, arrivals either bunched or spread
   task automatic test_random();
      int n;
      while (n_items < ItemTarget) begin
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(30, ProcCap);
            1:       n = 1;
            default: n = $urandom_range(2, 10);
         endcase
         if (n > ItemTarget - n_items) n = ItemTarget - n_items;
         stall_mode = $urandom_range(0, 3);
         random_batch(n, ($urandom_range(0, 1) != 0) ? 65535 : 300,
                      ($urandom_range(0, 1) != 0) ? 255 : 2);
         if ($urandom_range(0, 3) == 0) wait_drained();
      end
      wait_drained();
   endtask

   // receiver: stall pattern of its own, or held off by a test
   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_ready <= 1'b0;
      end else begin
         case (stall_mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 3) != 0);
            2:       rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ~rsp_ready;
         endcase
      end
   end

   // result checker against the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (schedule_q.size() == 0) begin
            $error("result with no expectation pending: %p", rsp_data);
            n_errors++;
         end else begin
            e = schedule_q.pop_front();
            n_results++;
            if (rsp_data.process_index !== e.process_index) begin
               $error("process_index exp %0d got %0d", e.process_index, rsp_data.process_index);
               n_errors++;
            end
            if (rsp_data.start_at !== e.start_at) begin
               $error("start_at exp %0d got %0d", e.start_at, rsp_data.start_at);
               n_errors++;
            end
            if (rsp_data.finish_at !== e.finish_at) begin
               $error("finish_at exp %0d got %0d", e.finish_at, rsp_data.finish_at);
               n_errors++;
            end
            if (rsp_data.turnaround !== e.turnaround) begin
               $error("turnaround exp %0d got %0d", e.turnaround, rsp_data.turnaround);
               n_errors++;
            end
            if (rsp_data.wait_len !== e.wait_len) begin
               $error("wait_len exp %0d got %0d", e.wait_len, rsp_data.wait_len);
               n_errors++;
            end
            if (rsp_data.respond_len !== e.respond_len) begin
               $error("respond_len exp %0d got %0d", e.respond_len, rsp_data.respond_len);
               n_errors++;
            end
            if (rsp_data.sum_turnaround !== e.sum_turnaround) begin
               $error("sum_turnaround exp %0d got %0d", e.sum_turnaround, rsp_data.sum_turnaround);
               n_errors++;
            end
            if (rsp_data.sum_waiting !== e.sum_waiting) begin
               $error("sum_waiting exp %0d got %0d", e.sum_waiting, rsp_data.sum_waiting);
               n_errors++;
            end
            if (rsp_data.sum_response !== e.sum_response) begin
               $error("sum_response exp %0d got %0d", e.sum_response, rsp_data.sum_response);
               n_errors++;
            end
            if (rsp_data.sum_idle !== e.sum_idle) begin
               $error("sum_idle exp %0d got %0d", e.sum_idle, rsp_data.sum_idle);
               n_errors++;
            end
            if (rsp_data.last_result !== e.last_result) begin
               $error("last_result exp %0d got %0d", e.last_result, rsp_data.last_result);
               n_errors++;
            end
         end
      end
   end

   // watchdog on a cycle counter
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      hold_off   = 1'b0;
      stall_mode = 1;
      n_loaded = 0; n_errors = 0; n_results = 0; n_batches = 0; n_items = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_batch_full();
      test_backpressure();
      test_random();
      // allow any trailing activity to show up as an unexpected result
      repeat (200) @(posedge clock);
      if (schedule_q.size() != 0) begin
         $error("%0d expected results never arrived", schedule_q.size());
         n_errors++;
      end
      $display("covered %0d loads in %0d batches, %0d schedule results checked",
               n_items, n_batches, n_results);
      if (n_errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// File: files.f
design/ps_pkg.sv
design/ps_cell.sv
design/priority_schedule.sv
verif/testbench.sv
